@@ src/imhdk_pkg.sv @@
`timescale 1ns / 1ps
package imhdk_pkg;
   localparam int VerticesDefault = 1024;
   localparam int KeyBitsDefault  = 31;
   localparam int VertexW = 10;
   localparam int KeyW    = 31;
   localparam int StatusW = 3;
   localparam int OccW    = 11;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_EXTRACT  = 2'd1,
      OP_DECREASE = 2'd2,
      OP_NOP      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_EMPTY       = 3'd1,
      ST_FULL        = 3'd2,
      ST_PRESENT     = 3'd3,
      ST_ABSENT      = 3'd4,
      ST_NOT_SMALLER = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [VertexW-1:0] vertex;
      logic [KeyW-1:0]    key;
   } req_type;

   typedef struct packed {
      logic [VertexW-1:0] min_vertex;
      logic [KeyW-1:0]    min_key;
      logic [StatusW-1:0] status;
      logic [OccW-1:0]    occupancy;
   } rsp_type;
endpackage

@@ src/indexed_min_heap_decrease_key_top.sv @@
`timescale 1ns / 1ps
// Indexed binary min-heap of (vertex, key) pairs with decrease-key.
// Command channel: drive req_data and raise start while busy is low; the
// transfer happens on that edge and busy is high from the next cycle.
// Operations: insert, extract minimum, decrease key; the fourth code is a no-op.
// Result channel: rsp_valid is high for exactly one cycle with rsp_data, and
// exactly one result follows every transfer. The receiver cannot stall.
// Order of work: a no-op or a command refused on its fields or the count goes
// straight to the result; a refusal on presence follows the position lookup,
// and a key that is not smaller follows the slot read after it. A sift works
// level by level upwards and downwards (parent or both children read, compare,
// write). The single slot memory read port sets this.
// Busy drops in the strobe cycle, so the next command can transfer at the edge
// that ends it: one command at a time, no overlap.
// Reset clears the entry count, then a clearing pass zeroes all VERTICES
// entries of the position memory with busy held high; a zero
// position marks an absent vertex. Slot memories are undefined until written.
module indexed_min_heap_decrease_key_top #(
   parameter int VERTICES = imhdk_pkg::VerticesDefault,
   parameter int KEY_BITS = imhdk_pkg::KeyBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  imhdk_pkg::req_type  req_data,
   output logic                rsp_valid,
   output imhdk_pkg::rsp_type  rsp_data
);
   localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
   localparam int SW = $clog2(VERTICES + 1); // slot index 0..VERTICES
   localparam int PW = SW + 1;               // holds 2p+1

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LOOK, S_DEC_CHK, S_EXT_ROOT, S_EXT_LAST,
      S_UP, S_UP_CMP, S_DN, S_DN_L, S_DN_R, S_PLACE, S_DONE
   } state_type;

   // memories; slot s lives at address s-1
   logic [KEY_BITS-1:0] key_mem [VERTICES];
   logic [VW-1:0]       vtx_mem [VERTICES];
   logic [SW-1:0]       pos_mem [VERTICES];

   state_type           state_ff;
   imhdk_pkg::op_type   op_ff;
   logic [SW-1:0]       count_ff;
   logic [SW-1:0]       p_ff;
   // moving entry, and the left child held while the right one is read
   logic [KEY_BITS-1:0] pk_ff, ck_ff;
   logic [VW-1:0]       pv_ff, cv_ff;
   logic [VW-1:0]       clr_ff;
   logic [KEY_BITS-1:0] krd_ff;
   logic [VW-1:0]       vrd_ff;
   logic [SW-1:0]       posrd_ff;
   imhdk_pkg::rsp_type  rsp_ff;
   logic                rsp_valid_ff;

   // memory port controls
   logic                slot_we;
   logic [SW-1:0]       slot_wa, slot_ra;
   logic [VW-1:0]       slot_wa_a, slot_ra_a;
   logic [KEY_BITS-1:0] slot_wk;
   logic [VW-1:0]       slot_wv;
   logic                pos_we;
   logic [VW-1:0]       pos_wa, pos_ra;
   logic [SW-1:0]       pos_wd;

   // chosen child during a sift down
   logic [KEY_BITS-1:0] dn_k;
   logic [VW-1:0]       dn_v;
   logic [SW-1:0]       dn_idx;

   logic [VW-1:0]       req_v;
   logic                in_range;
   logic [KEY_BITS-1:0] req_k;
   logic [PW-1:0]       left_idx, right_idx, cnt_ext;

   assign req_v     = VW'(req_data.vertex);
   assign in_range  = ({22'd0, req_data.vertex} < 32'(VERTICES));
   assign req_k     = KEY_BITS'(req_data.key);
   assign left_idx  = {p_ff, 1'b0};
   assign right_idx = {p_ff, 1'b1};
   assign cnt_ext   = PW'(count_ff);
   assign slot_wa_a = VW'(slot_wa - SW'(1));
   assign slot_ra_a = VW'(slot_ra - SW'(1));
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (slot_we) begin
         key_mem[slot_wa_a] <= slot_wk;
         vtx_mem[slot_wa_a] <= slot_wv;
      end
      if (pos_we) pos_mem[pos_wa] <= pos_wd;
      krd_ff   <= key_mem[slot_ra_a];
      vrd_ff   <= vtx_mem[slot_ra_a];
      posrd_ff <= pos_mem[pos_ra];
   end

   // take the right child only when it is strictly smaller than the left
   always_comb begin
      if (state_ff == S_DN_R && !(ck_ff > krd_ff)) begin
         dn_k = ck_ff; dn_v = cv_ff; dn_idx = SW'(left_idx);
      end else if (state_ff == S_DN_R) begin
         dn_k = krd_ff; dn_v = vrd_ff; dn_idx = SW'(right_idx);
      end else begin
         dn_k = krd_ff; dn_v = vrd_ff; dn_idx = SW'(left_idx);
      end
   end

   always_comb begin
      slot_ra = SW'(1);
      slot_we = 1'b0; slot_wa = p_ff; slot_wk = pk_ff; slot_wv = pv_ff;
      pos_we  = 1'b0; pos_wa = pv_ff; pos_wd = p_ff;
      pos_ra  = req_v;
      unique case (state_ff)
         S_CLEAR: begin
            pos_we = 1'b1; pos_wa = clr_ff; pos_wd = '0;
         end
         S_IDLE:     slot_ra = SW'(1); // root, for extract
         S_LOOK:     slot_ra = posrd_ff;
         S_DEC_CHK:  slot_ra = SW'(1);
         S_EXT_ROOT: slot_ra = count_ff;
         S_EXT_LAST: begin
            // drop the removed vertex from the map
            pos_we = 1'b1; pos_wa = cv_ff; pos_wd = '0;
         end
         S_UP:       slot_ra = p_ff >> 1;
         S_UP_CMP: begin
            // move the parent down into the hole
            if (pk_ff < krd_ff) begin
               slot_we = 1'b1; slot_wk = krd_ff; slot_wv = vrd_ff;
               pos_we  = 1'b1; pos_wa = vrd_ff;
            end
         end
         S_DN:       slot_ra = SW'(left_idx);
         S_DN_L: begin
            slot_ra = SW'(right_idx);
            if (left_idx >= cnt_ext && dn_k < pk_ff) begin
               slot_we = 1'b1; slot_wk = dn_k; slot_wv = dn_v;
               pos_we  = 1'b1; pos_wa = dn_v;
            end
         end
         S_DN_R: begin
            // move the smaller child up into the hole
            if (dn_k < pk_ff) begin
               slot_we = 1'b1; slot_wk = dn_k; slot_wv = dn_v;
               pos_we  = 1'b1; pos_wa = dn_v;
            end
         end
         S_PLACE: begin
            slot_we = 1'b1;
            pos_we  = 1'b1;
         end
         S_DONE:     slot_ra = SW'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + VW'(1);
               if (clr_ff == VW'(VERTICES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (start) begin
               op_ff  <= imhdk_pkg::op_type'(req_data.operation);
               pk_ff  <= req_k;
               pv_ff  <= req_v;
               rsp_ff <= '0;
               unique case (imhdk_pkg::op_type'(req_data.operation))
                  imhdk_pkg::OP_INSERT: begin
                     if (!in_range) begin
                        rsp_ff.status <= imhdk_pkg::ST_ABSENT; state_ff <= S_DONE;
                     end else if (count_ff >= SW'(VERTICES)) begin
                        rsp_ff.status <= imhdk_pkg::ST_FULL; state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_LOOK;
                     end
                  end
                  imhdk_pkg::OP_EXTRACT: begin
                     if (count_ff == '0) begin
                        rsp_ff.status <= imhdk_pkg::ST_EMPTY; state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_EXT_ROOT;
                     end
                  end
                  imhdk_pkg::OP_DECREASE: begin
                     if (!in_range) begin
                        rsp_ff.status <= imhdk_pkg::ST_ABSENT; state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_LOOK;
                     end
                  end
                  imhdk_pkg::OP_NOP: state_ff <= S_DONE;
               endcase
            end
            S_LOOK: begin
               // position of the vertex has arrived; zero means absent
               if (op_ff == imhdk_pkg::OP_INSERT) begin
                  if (posrd_ff != '0) begin
                     rsp_ff.status <= imhdk_pkg::ST_PRESENT; state_ff <= S_DONE;
                  end else begin
                     count_ff <= count_ff + SW'(1);
                     p_ff     <= count_ff + SW'(1);
                     state_ff <= S_UP;
                  end
               end else if (posrd_ff == '0 || posrd_ff > count_ff) begin
                  rsp_ff.status <= imhdk_pkg::ST_ABSENT; state_ff <= S_DONE;
               end else begin
                  p_ff     <= posrd_ff;
                  state_ff <= S_DEC_CHK;
               end
            end
            S_DEC_CHK: begin
               if (pk_ff < krd_ff) state_ff <= S_UP;
               else begin
                  rsp_ff.status <= imhdk_pkg::ST_NOT_SMALLER; state_ff <= S_DONE;
               end
            end
            S_EXT_ROOT: begin
               rsp_ff.min_vertex <= imhdk_pkg::VertexW'(vrd_ff);
               rsp_ff.min_key    <= imhdk_pkg::KeyW'(krd_ff);
               cv_ff    <= vrd_ff;
               state_ff <= S_EXT_LAST;
            end
            S_EXT_LAST: begin
               // last entry moves to the root and sinks
               pk_ff    <= krd_ff;
               pv_ff    <= vrd_ff;
               p_ff     <= SW'(1);
               count_ff <= count_ff - SW'(1);
               state_ff <= (count_ff == SW'(1)) ? S_DONE : S_DN;
            end
            S_UP: state_ff <= (p_ff <= SW'(1)) ? S_PLACE : S_UP_CMP;
            S_UP_CMP: begin
               if (pk_ff < krd_ff) begin
                  p_ff     <= p_ff >> 1;
                  state_ff <= S_UP;
               end else state_ff <= S_PLACE;
            end
            S_DN: state_ff <= (left_idx > cnt_ext) ? S_PLACE : S_DN_L;
            S_DN_L: begin
               if (left_idx < cnt_ext) begin
                  ck_ff    <= krd_ff;
                  cv_ff    <= vrd_ff;
                  state_ff <= S_DN_R;
               end else if (dn_k < pk_ff) begin
                  p_ff     <= dn_idx;
                  state_ff <= S_DN;
               end else state_ff <= S_PLACE;
            end
            S_DN_R: begin
               if (dn_k < pk_ff) begin
                  p_ff     <= dn_idx;
                  state_ff <= S_DN;
               end else state_ff <= S_PLACE;
            end
            S_PLACE: state_ff <= S_DONE;
            S_DONE: begin
               rsp_ff.occupancy <= imhdk_pkg::OccW'(count_ff);
               rsp_valid_ff     <= 1'b1;
               state_ff         <= S_IDLE;
            end
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command transfer did not raise busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.occupancy <= imhdk_pkg::OccW'(VERTICES)))
      else $error("occupancy beyond capacity");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != imhdk_pkg::ST_OK) |->
         (rsp_data.min_vertex == '0 && rsp_data.min_key == '0))
      else $error("refused command returned a minimum");
endmodule

@@ bench/heap_checker.sv @@
`timescale 1ns / 1ps
module heap_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  imhdk_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  imhdk_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 pending
);
   localparam int Depth = imhdk_pkg::VerticesDefault;
   localparam int KW    = imhdk_pkg::KeyW;
   localparam int VW    = imhdk_pkg::VertexW;

   logic [KW-1:0]      heap_key [1:Depth];
   logic [VW-1:0]      heap_vtx [1:Depth];
   int                 slot_of [0:Depth-1];
   bit                 present [0:Depth-1];
   int                 count;
   imhdk_pkg::rsp_type expected_q[$];

   function automatic void swap_slots(int a, int b);
      logic [KW-1:0] k;
      logic [VW-1:0] v;
      k = heap_key[a]; v = heap_vtx[a];
      heap_key[a] = heap_key[b]; heap_vtx[a] = heap_vtx[b];
      heap_key[b] = k; heap_vtx[b] = v;
      slot_of[heap_vtx[a]] = a;
      slot_of[heap_vtx[b]] = b;
   endfunction

   function automatic void sift_up(int p);
      while (p > 1 && heap_key[p] < heap_key[p/2]) begin
         swap_slots(p, p/2);
         p = p/2;
      end
   endfunction

   function automatic void sift_down(int p);
      int c;
      while (2*p <= count) begin
         c = 2*p;
         if (c < count && heap_key[c] > heap_key[c+1]) c++;
         if (heap_key[c] < heap_key[p]) begin
            swap_slots(c, p);
            p = c;
         end else break;
      end
   endfunction

   function automatic imhdk_pkg::rsp_type apply_command(imhdk_pkg::req_type r);
      imhdk_pkg::rsp_type o;
      int                 p;
      int                 v;
      o = '0;
      v = int'(r.vertex);
      case (r.operation)
         imhdk_pkg::OP_INSERT: begin
            if (v >= Depth) o.status = imhdk_pkg::ST_ABSENT;
            else if (count >= Depth) o.status = imhdk_pkg::ST_FULL;
            else if (present[v]) o.status = imhdk_pkg::ST_PRESENT;
            else begin
               count++;
               heap_key[count] = r.key;
               heap_vtx[count] = r.vertex;
               slot_of[v] = count;
               present[v] = 1;
               sift_up(count);
            end
         end
         imhdk_pkg::OP_EXTRACT: begin
            if (count == 0) o.status = imhdk_pkg::ST_EMPTY;
            else begin
               o.min_vertex = heap_vtx[1];
               o.min_key = heap_key[1];
               swap_slots(1, count);
               count--;
               present[o.min_vertex] = 0;
               if (count > 0) sift_down(1);
            end
         end
         imhdk_pkg::OP_DECREASE: begin
            if (v >= Depth || !present[v]) o.status = imhdk_pkg::ST_ABSENT;
            else begin
               p = slot_of[v];
               if (p == 0 || p > count) o.status = imhdk_pkg::ST_ABSENT;
               else if (!(r.key < heap_key[p])) o.status = imhdk_pkg::ST_NOT_SMALLER;
               else begin
                  heap_key[p] = r.key;
                  sift_up(p);
               end
            end
         end
         default: ;
      endcase
      o.occupancy = imhdk_pkg::OccW'(count);
      return o;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      imhdk_pkg::rsp_type e;
      if (!reset) begin
         // compare first: a result and a new transfer may share an edge
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report("unrequested result", 64'(rsp_data.status), 64'd0);
            end else begin
               e = expected_q.pop_front();
               if (rsp_data.min_vertex !== e.min_vertex)
                  report("min_vertex", 64'(rsp_data.min_vertex), 64'(e.min_vertex));
               if (rsp_data.min_key !== e.min_key)
                  report("min_key", 64'(rsp_data.min_key), 64'(e.min_key));
               if (rsp_data.status !== e.status)
                  report("status", 64'(rsp_data.status), 64'(e.status));
               if (rsp_data.occupancy !== e.occupancy)
                  report("occupancy", 64'(rsp_data.occupancy), 64'(e.occupancy));
            end
         end
         if (start && !busy) expected_q.push_back(apply_command(req_data));
      end
      pending <= expected_q.size();
   end
endmodule

@@ bench/tb_indexed_min_heap_decrease_key_top.sv @@
`timescale 1ns / 1ps
module tb_indexed_min_heap_decrease_key_top;
   localparam int VW = imhdk_pkg::VertexW;
   localparam int KW = imhdk_pkg::KeyW;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   imhdk_pkg::req_type req_data;
   logic               rsp_valid;
   imhdk_pkg::rsp_type rsp_data;
   int                 fail_count;
   int                 pending;

   // vertices handed out so far, to aim decreases and duplicates at live entries
   logic [VW-1:0] used_vtx[$];

   indexed_min_heap_decrease_key_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   heap_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Present one command and hold start until the transfer edge; the caller
   // drops start or follows straight on with another command.
   task automatic send(imhdk_pkg::op_type op, logic [VW-1:0] v, logic [KW-1:0] k);
      req_data <= '{operation: op, vertex: v, key: k};
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic pause(bit allowed);
      int n;
      if (allowed && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Random key, sometimes from a narrow band so ties occur, sometimes extreme.
   function automatic logic [KW-1:0] pick_key();
      logic [KW-1:0] k;
      case ($urandom_range(0, 5))
         0: k = KW'($urandom_range(0, 7));
         1: k = {KW{1'b1}} - KW'($urandom_range(0, 3));
         default: k = KW'($urandom());
      endcase
      return k;
   endfunction

   function automatic logic [VW-1:0] pick_vertex();
      logic [VW-1:0] v;
      if (used_vtx.size() > 0 && $urandom_range(0, 2) != 0)
         v = used_vtx[$urandom_range(0, used_vtx.size() - 1)];
      else v = VW'($urandom());
      return v;
   endfunction

   initial begin
      logic [VW-1:0] v;
      int            r;
      start = 0;
      req_data = '0;
      reset = 1;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty extract, extremes, duplicate, absent, not smaller, no-op
      send(imhdk_pkg::OP_EXTRACT, '0, '0);
      send(imhdk_pkg::OP_DECREASE, VW'(5), KW'(3));
      send(imhdk_pkg::OP_INSERT, '0, {KW{1'b1}});
      send(imhdk_pkg::OP_INSERT, {VW{1'b1}}, '0);
      send(imhdk_pkg::OP_INSERT, '0, KW'(7));
      send(imhdk_pkg::OP_INSERT, VW'(12), KW'(100));
      send(imhdk_pkg::OP_INSERT, VW'(13), KW'(100));
      send(imhdk_pkg::OP_INSERT, VW'(14), KW'(50));
      send(imhdk_pkg::OP_DECREASE, VW'(12), KW'(100));
      send(imhdk_pkg::OP_DECREASE, VW'(12), KW'(200));
      send(imhdk_pkg::OP_DECREASE, '0, '0);
      send(imhdk_pkg::OP_DECREASE, VW'(13), KW'(49));
      send(imhdk_pkg::OP_NOP, {VW{1'b1}}, {KW{1'b1}});
      send(imhdk_pkg::OP_DECREASE, VW'(77), KW'(1));
      repeat (6) send(imhdk_pkg::OP_EXTRACT, {VW{1'b1}}, {KW{1'b1}});

      // random mix weighted to insert and decrease so the heap stays populated
      for (int i = 0; i < 730; i++) begin
         r = $urandom_range(0, 9);
         v = pick_vertex();
         if (r < 4) begin
            send(imhdk_pkg::OP_INSERT, v, pick_key());
            used_vtx.push_back(v);
         end else if (r < 7) send(imhdk_pkg::OP_DECREASE, v, pick_key());
         else if (r < 9) send(imhdk_pkg::OP_EXTRACT, VW'($urandom()), KW'($urandom()));
         else send(imhdk_pkg::OP_NOP, VW'($urandom()), KW'($urandom()));
         pause(i < 630);
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #500000;
      $display("== FAIL ==");
      $finish;
   end
endmodule
